FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define NPS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define NPS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/nps_pkg.sv
// Types and constants shared by the priority scheduler modules.
package nps_pkg;

  localparam int ID_W      = 8;
  localparam int PRI_W     = 8;
  localparam int ARR_W     = 16;
  localparam int BUR_W     = 16;
  localparam int TIME_W    = 22;
  localparam int ENTRY_W   = ID_W + PRI_W + ARR_W + BUR_W;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 80;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // One stored job, identifier in the top bits.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
  } job_entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_PICK,
    ST_EMIT
  } sched_state_t;

endpackage

FILE: sv/nps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/nonpreemptive_priority_scheduler_top.sv
// Top level of the non-preemptive priority scheduler.
//
// The block takes a list of jobs on the input stream, one transaction per job
// and one per cycle while loading, and stores each job in an on-chip table
// memory. The transaction with tlast set is stored like the others and starts
// scheduling; jobs beyond MAX_JOBS are dropped, but their tlast still starts
// the run. The scheduler clock starts at zero. For every pick, a scan through
// the table memory (one entry per cycle, registered read data) finds both the
// best job that has already arrived (highest priority, then earliest arrival,
// then earliest load) and the best job among those with the earliest pending
// arrival; if no job is ready, the clock jumps to that arrival and the second
// candidate runs. One result transaction per job follows, in run order, with
// tlast on the last one. Each result passes through the table scan, a drain
// state for the last memory read, a pick state that computes the completion
// time and an emit state that loads the output register once it is free. The
// completion time saturates at its 22-bit maximum. After the last result the
// block is ready for a new list; the output register holds a result while the
// next list is already being loaded.
module nonpreemptive_priority_scheduler_top
  import nps_pkg::*;
#(
  parameter int MAX_JOBS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // job_id [7:0], job_priority [15:8], arrival_time [31:16], burst_time [47:32]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // done_id [7:0], completion_time [29:8], turnaround_time [51:30],
  // waiting_time [73:52], zero padding [79:74]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

  sched_state_t state_r, state_nxt;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    picks_r, picks_nxt;
  logic [TIME_W-1:0]   cur_r, cur_nxt;
  logic [MAX_JOBS-1:0] done_r, done_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                v_r, v_nxt;
  logic [IDX_W-1:0]    idx_d_r, idx_d_nxt;

  // Candidate A: best ready job. Candidate B: best job of earliest arrival.
  logic                fa_r, fa_nxt, fb_r, fb_nxt;
  job_entry_t          a_ent_r, a_ent_nxt, b_ent_r, b_ent_nxt;
  logic [IDX_W-1:0]    a_idx_r, a_idx_nxt, b_idx_r, b_idx_nxt;

  job_entry_t          sel_ent_r, sel_ent_nxt;
  logic [TIME_W-1:0]   comp_r, comp_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_last_r, out_last_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TIME_W-1:0]   out_comp_r, out_comp_nxt;
  logic [TIME_W-1:0]   out_tat_r, out_tat_nxt;
  logic [TIME_W-1:0]   out_wt_r, out_wt_nxt;

  logic                ram_we;
  logic [ENTRY_W-1:0]  ram_rd_data;
  job_entry_t          rd_ent;
  logic [IDX_W-1:0]    last_idx;

  nps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_JOBS)
  ) u_job_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (in_tdata[ENTRY_W-1:0]),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  // Input packs id in the low byte; the table entry keeps the burst low.
  assign rd_ent = job_entry_t'({ram_rd_data[ID_W-1:0],
                                ram_rd_data[ID_W+PRI_W-1:ID_W],
                                ram_rd_data[ID_W+PRI_W+ARR_W-1:ID_W+PRI_W],
                                ram_rd_data[ENTRY_W-1:ID_W+PRI_W+ARR_W]});

  assign last_idx = IDX_W'(cnt_r - CNT_W'(1));

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W - ID_W - 3 * TIME_W){1'b0}},
                       out_wt_r, out_tat_r, out_comp_r, out_id_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      picks_r     <= '0;
      cur_r       <= '0;
      done_r      <= '0;
      rd_idx_r    <= '0;
      v_r         <= 1'b0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      picks_r     <= picks_nxt;
      cur_r       <= cur_nxt;
      done_r      <= done_nxt;
      rd_idx_r    <= rd_idx_nxt;
      v_r         <= v_nxt;
      fa_r        <= fa_nxt;
      fb_r        <= fb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r    <= idx_d_nxt;
    a_ent_r    <= a_ent_nxt;
    a_idx_r    <= a_idx_nxt;
    b_ent_r    <= b_ent_nxt;
    b_idx_r    <= b_idx_nxt;
    sel_ent_r  <= sel_ent_nxt;
    comp_r     <= comp_nxt;
    out_last_r <= out_last_nxt;
    out_id_r   <= out_id_nxt;
    out_comp_r <= out_comp_nxt;
    out_tat_r  <= out_tat_nxt;
    out_wt_r   <= out_wt_nxt;
  end

  logic              ready_c, undone_c;
  logic              start_jump;
  job_entry_t        pick_ent;
  logic [TIME_W-1:0] start_t;
  logic [TIME_W:0]   sum_t;
  logic [TIME_W-1:0] arr_ext, bur_ext, tat_c;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    picks_nxt     = picks_r;
    cur_nxt       = cur_r;
    done_nxt      = done_r;
    rd_idx_nxt    = rd_idx_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    a_ent_nxt     = a_ent_r;
    a_idx_nxt     = a_idx_r;
    b_ent_nxt     = b_ent_r;
    b_idx_nxt     = b_idx_r;
    sel_ent_nxt   = sel_ent_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_id_nxt    = out_id_r;
    out_comp_nxt  = out_comp_r;
    out_tat_nxt   = out_tat_r;
    out_wt_nxt    = out_wt_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    v_nxt         = (state_r == ST_SCAN);
    idx_d_nxt     = rd_idx_r;

    // Scan step: compare the entry read last cycle with both candidates.
    // Entries come in load order, so a full tie keeps the earlier one.
    undone_c = !done_r[idx_d_r];
    ready_c  = undone_c && (TIME_W'(rd_ent.arr) <= cur_r);
    if (v_r) begin
      if (ready_c && (!fa_r || (rd_ent.pri > a_ent_r.pri) ||
                      ((rd_ent.pri == a_ent_r.pri) && (rd_ent.arr < a_ent_r.arr)))) begin
        fa_nxt    = 1'b1;
        a_ent_nxt = rd_ent;
        a_idx_nxt = idx_d_r;
      end
      if (undone_c && (!fb_r || (rd_ent.arr < b_ent_r.arr) ||
                       ((rd_ent.arr == b_ent_r.arr) && (rd_ent.pri > b_ent_r.pri)))) begin
        fb_nxt    = 1'b1;
        b_ent_nxt = rd_ent;
        b_idx_nxt = idx_d_r;
      end
    end

    // Completion time of the picked job, saturated in the pick state.
    start_jump = !fa_r;
    pick_ent   = start_jump ? b_ent_r : a_ent_r;
    start_t    = start_jump ? TIME_W'(b_ent_r.arr) : cur_r;
    sum_t      = {1'b0, start_t} + (TIME_W + 1)'(pick_ent.bur);

    // Turnaround and waiting time of the registered pick.
    arr_ext = TIME_W'(sel_ent_r.arr);
    bur_ext = TIME_W'(sel_ent_r.bur);
    tat_c   = (comp_r >= arr_ext) ? (comp_r - arr_ext) : '0;

    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (cnt_r < CNT_MAX) begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_tlast) begin
            state_nxt  = ST_SCAN;
            rd_idx_nxt = '0;
            fa_nxt     = 1'b0;
            fb_nxt     = 1'b0;
            picks_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
        if (rd_idx_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        sel_ent_nxt = pick_ent;
        comp_nxt    = (sum_t > {1'b0, TIME_MAX}) ? TIME_MAX : sum_t[TIME_W-1:0];
        cur_nxt     = comp_nxt;
        if (start_jump) begin
          done_nxt[b_idx_r] = 1'b1;
        end else begin
          done_nxt[a_idx_r] = 1'b1;
        end
        picks_nxt = picks_r + CNT_W'(1);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (picks_r == cnt_r);
          out_id_nxt    = sel_ent_r.id;
          out_comp_nxt  = comp_r;
          out_tat_nxt   = tat_c;
          out_wt_nxt    = (tat_c >= bur_ext) ? (tat_c - bur_ext) : '0;
          if (picks_r == cnt_r) begin
            cnt_nxt   = '0;
            cur_nxt   = '0;
            done_nxt  = '0;
            state_nxt = ST_LOAD;
          end else begin
            rd_idx_nxt = '0;
            fa_nxt     = 1'b0;
            fb_nxt     = 1'b0;
            state_nxt  = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

FILE: sv/nps_checker.sv
// Port-level checker for the priority scheduler, bound to the top level.
`include "assert_macros.svh"

module nps_checker
  import nps_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tlast,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // A stalled result transaction stays offered.
  `NPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // A stalled result transaction keeps its payload.
  `NPS_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // The last job of a list starts scheduling, so loading stops.
  `NPS_ASSERT_NEXT(a_load_stops, in_tvalid && in_tready && in_tlast, !in_tready, "input taken after end of list")

  // Nothing follows the final result until a new list is loaded.
  `NPS_ASSERT_NEXT(a_end_quiet, out_tvalid && out_tready && out_tlast, !out_tvalid, "result after final result")

  // The output padding bits are always zero.
  `NPS_ASSERT(a_pad_zero, out_tdata[OUT_DATA_W-1:ID_W+3*TIME_W] == '0, "nonzero output padding")

endmodule

bind nonpreemptive_priority_scheduler_top nps_checker u_nps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tlast   (in_tlast),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

FILE: bench/testbench.sv
// Self-checking testbench for the non-preemptive priority scheduler top level.
module testbench
  import nps_pkg::*;
();

  localparam int MAX_JOBS = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int DRAIN_CYCLES = 2 * (MAX_JOBS + 3);

  // One job as it is loaded, and one scheduled job as it is reported.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic             last;
  } job_load_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] finish;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              last;
  } job_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  job_load_t   pending_loads[$];
  job_load_t   loaded_jobs[$];
  job_report_t expected_reports[$];
  job_load_t   next_load;
  job_report_t seen_report;
  job_report_t want_report;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int loads_queued = 0;
  int loads_accepted = 0;
  int error_count = 0;
  int cycle_count = 0;

  nonpreemptive_priority_scheduler_top #(
    .MAX_JOBS (MAX_JOBS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #5 clk = ~clk;

  // Runs the stored list to completion and queues one report per job, in run order.
  // The clock jumps forward whenever nothing has arrived yet.
  function automatic void schedule_loaded_jobs();
    bit          finished [MAX_JOBS];
    int          count;
    int          best;
    int unsigned clock_now;
    int unsigned earliest;
    int unsigned turnaround;
    job_report_t report;
    count = loaded_jobs.size();
    clock_now = 0;
    for (int i = 0; i < MAX_JOBS; i++) finished[i] = 1'b0;
    for (int k = 0; k < count; k++) begin
      earliest = 32'hFFFF_FFFF;
      for (int i = 0; i < count; i++) begin
        if (!finished[i] && loaded_jobs[i].arr < earliest) earliest = loaded_jobs[i].arr;
      end
      if (earliest > clock_now) clock_now = earliest;
      best = -1;
      for (int i = 0; i < count; i++) begin
        if (finished[i] || loaded_jobs[i].arr > clock_now) continue;
        // Strict comparisons keep the earlier load order on a full tie.
        if (best < 0 || loaded_jobs[i].pri > loaded_jobs[best].pri ||
            (loaded_jobs[i].pri == loaded_jobs[best].pri &&
             loaded_jobs[i].arr < loaded_jobs[best].arr)) begin
          best = i;
        end
      end
      finished[best] = 1'b1;
      clock_now = clock_now + loaded_jobs[best].bur;
      if (clock_now > TIME_MAX) clock_now = TIME_MAX;
      turnaround = (clock_now >= loaded_jobs[best].arr) ? clock_now - loaded_jobs[best].arr : 0;
      report.id = loaded_jobs[best].id;
      report.finish = clock_now[TIME_W-1:0];
      report.turnaround = turnaround[TIME_W-1:0];
      report.waiting = (turnaround >= loaded_jobs[best].bur) ?
                       TIME_W'(turnaround - loaded_jobs[best].bur) : '0;
      report.last = (k + 1 == count);
      expected_reports.push_back(report);
    end
    loaded_jobs.delete();
  endfunction

  task automatic queue_job(input int id, input int pri, input int arr, input int bur,
                           input bit last);
    job_load_t job;
    job.id = ID_W'(id);
    job.pri = PRI_W'(pri);
    job.arr = ARR_W'(arr);
    job.bur = BUR_W'(bur);
    job.last = last;
    pending_loads.push_back(job);
    loads_queued++;
  endtask

  // Driver: offers the next pending job once the previous transaction is gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_loads.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_load = pending_loads.pop_front();
        in_tdata <= {next_load.bur, next_load.arr, next_load.pri, next_load.id};
        in_tlast <= next_load.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: feeds accepted jobs to the predictor and checks every result transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_stall_pct);
      if (in_tvalid && in_tready) begin
        if (loaded_jobs.size() < MAX_JOBS) begin
          loaded_jobs.push_back({in_tdata[7:0], in_tdata[15:8], in_tdata[31:16],
                                 in_tdata[47:32], in_tlast});
        end
        if (in_tlast) schedule_loaded_jobs();
        loads_accepted++;
      end
      if (out_tvalid && out_tready) begin
        seen_report = {out_tdata[7:0], out_tdata[29:8], out_tdata[51:30],
                       out_tdata[73:52], out_tlast};
        if (expected_reports.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("Unexpected result: id %0d finish %0d turnaround %0d waiting %0d last %0b",
                     seen_report.id, seen_report.finish, seen_report.turnaround,
                     seen_report.waiting, seen_report.last);
        end else begin
          want_report = expected_reports.pop_front();
          if (seen_report.id !== want_report.id ||
              seen_report.finish !== want_report.finish ||
              seen_report.turnaround !== want_report.turnaround ||
              seen_report.waiting !== want_report.waiting ||
              seen_report.last !== want_report.last) begin
            error_count++;
            if (error_count <= 10) begin
              $display("Mismatch expected: id %0d finish %0d turnaround %0d waiting %0d last %0b",
                       want_report.id, want_report.finish, want_report.turnaround,
                       want_report.waiting, want_report.last);
              $display("         actual:   id %0d finish %0d turnaround %0d waiting %0d last %0b",
                       seen_report.id, seen_report.finish, seen_report.turnaround,
                       seen_report.waiting, seen_report.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int phase_items;
    int list_len;
    int roll;
    int arr_span;
    int pri_span;
    int bur_span;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // A lone job with every field at its top value, then one with every field at zero.
    queue_job(255, 255, 65535, 65535, 1'b1);
    queue_job(0, 0, 0, 0, 1'b1);
    // Ties: equal priorities fall back to arrival, then to load order.
    queue_job(1, 1, 0, 10, 1'b0);
    queue_job(2, 7, 5, 3, 1'b0);
    queue_job(3, 7, 4, 3, 1'b0);
    queue_job(4, 7, 4, 2, 1'b0);
    queue_job(5, 0, 9, 0, 1'b1);
    // Idle processor: wide gaps between arrivals, first job arrives late.
    queue_job(10, 200, 100, 5, 1'b0);
    queue_job(11, 255, 1000, 65535, 1'b0);
    queue_job(12, 0, 10, 1, 1'b1);
    // Jobs arriving together: the first pick must honor priority, not load order.
    queue_job(20, 3, 50, 4, 1'b0);
    queue_job(21, 9, 50, 4, 1'b0);
    queue_job(22, 9, 50, 0, 1'b0);
    queue_job(23, 0, 50, 7, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
        default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        // Mostly short lists; some are longer, and a few fill or overflow the table.
        if (roll < 6) list_len = $urandom_range(MAX_JOBS + 4, MAX_JOBS);
        else if (roll < 20) list_len = $urandom_range(MAX_JOBS - 1, 13);
        else list_len = $urandom_range(12, 1);
        case ($urandom_range(3))
          0: arr_span = 0;
          1: arr_span = 15;
          2: arr_span = 255;
          default: arr_span = 65535;
        endcase
        pri_span = $urandom_range(1) ? 3 : 255;
        case ($urandom_range(2))
          0: bur_span = 3;
          1: bur_span = 40;
          default: bur_span = 65535;
        endcase
        for (int j = 0; j < list_len; j++) begin
          queue_job($urandom_range(255), $urandom_range(pri_span), $urandom_range(arr_span),
                    $urandom_range(bur_span), j == list_len - 1);
        end
        phase_items += list_len;
      end
      // The phase ends once every job is taken and every report has come back.
      do @(posedge clk);
      while (loads_accepted != loads_queued || expected_reports.size() != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      error_count++;
      $display("%0d expected results never arrived", expected_reports.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/nps_pkg.sv
sv/nps_ram.sv
sv/nonpreemptive_priority_scheduler_top.sv
sv/nps_checker.sv
bench/testbench.sv
